>>> hdl/mli_pkg.sv
// Shared types, constants and codes for the Mandelbrot lane iterator.
package mli_pkg;

    localparam int MAX_LANES     = 4;
    localparam int DEF_LANES     = 4;
    localparam int DEF_FRAC_BITS = 28;

    localparam int C_W       = 32;
    localparam int CNT_W     = 16;
    localparam int NORM_W    = 32;
    localparam int PROD_W    = 2 * C_W;
    localparam int ITER_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIM  = 2'd2;

    localparam logic [ITER_W-1:0] RST_MAX_ITER = 16'd256;
    localparam logic [NORM_W-1:0] RST_NORM_THR = 32'd600239927;
    localparam logic [NORM_W-1:0] RST_ESC_LIM  = 32'd1073741824;
    localparam logic [NORM_W-1:0] NORM_SAT     = 32'hFFFF_FFFF;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SEL  = 10'b00_0000_0010,
        S_AA   = 10'b00_0000_0100,
        S_BB   = 10'b00_0000_1000,
        S_AB   = 10'b00_0001_0000,
        S_RI   = 10'b00_0010_0000,
        S_RR   = 10'b00_0100_0000,
        S_II   = 10'b00_1000_0000,
        S_UPD  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic signed [C_W-1:0] a;
        logic signed [C_W-1:0] b;
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
    } t_step_opd;

    typedef struct packed {
        logic signed [C_W-1:0] re;
        logic signed [C_W-1:0] im;
        logic                  inrange;
        logic [NORM_W-1:0]     norm;
    } t_step_res;

endpackage

>>> hdl/mli_step_unit.sv
// One complex step z*z + c and its squared magnitude on a shared 32x32 multiplier.
module mli_step_unit import mli_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  t_state    i_state,
    input  t_step_opd i_opd,
    output t_step_res o_res
);

    logic signed [C_W-1:0]    w_mul_a;
    logic signed [C_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_re_wide;
    logic signed [PROD_W-1:0] w_im_wide;
    logic                     w_fits;
    logic [PROD_W-1:0]        w_sq;
    logic [PROD_W-1:0]        w_sq_sh;
    logic [NORM_W-1:0]        w_norm;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [C_W-1:0]    r_re;
    logic signed [C_W-1:0]    r_im;
    logic                     r_inrange;

    // operand select per phase; the a*b product is the default
    always_comb begin
        unique case (i_state)
            S_AA: begin
                w_mul_a = i_opd.a;
                w_mul_b = i_opd.a;
            end
            S_BB: begin
                w_mul_a = i_opd.b;
                w_mul_b = i_opd.b;
            end
            S_RR: begin
                w_mul_a = r_re;
                w_mul_b = r_re;
            end
            S_II: begin
                w_mul_a = r_im;
                w_mul_b = r_im;
            end
            default: begin
                w_mul_a = i_opd.a;
                w_mul_b = i_opd.b;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // arithmetic shift gives the floor of the scaled products
    assign w_re_wide = (r_acc >>> FRAC_BITS) + PROD_W'(i_opd.cr);
    assign w_im_wide = (r_prod >>> (FRAC_BITS - 1)) + PROD_W'(i_opd.ci);
    assign w_fits    = (w_re_wide[PROD_W-1:C_W-1] == {(C_W+1){w_re_wide[C_W-1]}})
                    && (w_im_wide[PROD_W-1:C_W-1] == {(C_W+1){w_im_wide[C_W-1]}});

    // both squares are non-negative, so the sum stays inside 64 unsigned bits
    assign w_sq    = PROD_W'(r_acc) + PROD_W'(r_prod);
    assign w_sq_sh = w_sq >> FRAC_BITS;
    assign w_norm  = (!r_inrange || (|w_sq_sh[PROD_W-1:NORM_W])) ? NORM_SAT
                                                                 : w_sq_sh[NORM_W-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (i_state)
            S_BB: r_acc <= r_prod;
            S_AB: r_acc <= r_acc - r_prod;
            S_II: r_acc <= r_prod;
            S_RI: begin
                r_re      <= w_re_wide[C_W-1:0];
                r_im      <= w_im_wide[C_W-1:0];
                r_inrange <= w_fits;
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_res.re      = r_re;
    assign o_res.im      = r_im;
    assign o_res.inrange = r_inrange;
    assign o_res.norm    = w_norm;

endmodule

>>> hdl/mandelbrot_lane_iterator_top.sv
// One item at a time: a new item is taken only while the sequencer is idle, after the
// last result has been moved to the output register. Each lane step runs five products
// through the one shared 32x32 multiplier; a lane's steps are skipped once it has escaped.
// Reset (synchronous, active low): sequencer idle, result empty, registers to defaults.
// The next item may be taken while a finished result still waits to be taken.
module mandelbrot_lane_iterator_top import mli_pkg::*; #(
    parameter int LANES     = DEF_LANES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [C_W-1:0] i_c_real_0,
    input  logic signed [C_W-1:0] i_c_real_1,
    input  logic signed [C_W-1:0] i_c_real_2,
    input  logic signed [C_W-1:0] i_c_real_3,
    input  logic signed [C_W-1:0] i_c_imag,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CNT_W-1:0]      o_count_0,
    output logic [CNT_W-1:0]      o_count_1,
    output logic [CNT_W-1:0]      o_count_2,
    output logic [CNT_W-1:0]      o_count_3,
    output logic [NORM_W-1:0]     o_norm_0,
    output logic [NORM_W-1:0]     o_norm_1,
    output logic [NORM_W-1:0]     o_norm_2,
    output logic [NORM_W-1:0]     o_norm_3
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    t_state r_state, n_state;

    logic [ITER_W-1:0] r_max_iter;
    logic [NORM_W-1:0] r_norm_thr;
    logic [NORM_W-1:0] r_esc_lim;

    logic [LW-1:0]         r_lane;
    logic [ITER_W-1:0]     r_iter;
    logic signed [C_W-1:0] r_za [LANES];
    logic signed [C_W-1:0] r_zb [LANES];
    logic signed [C_W-1:0] r_cr [LANES];
    logic signed [C_W-1:0] r_ci;
    logic [CNT_W-1:0]      r_cnt  [LANES];
    logic [NORM_W-1:0]     r_norm [LANES];
    logic [LANES-1:0]      r_esc;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_cnt  [LANES];
    logic [NORM_W-1:0] r_out_norm [LANES];

    logic signed [C_W-1:0] w_cr_in  [MAX_LANES];
    logic [CNT_W-1:0]      w_cnt_o  [MAX_LANES];
    logic [NORM_W-1:0]     w_norm_o [MAX_LANES];

    logic      w_in_acc;
    logic      w_iter_end;
    logic      w_adv;
    logic      w_last_lane;
    logic      w_load_out;
    logic      w_escape;
    t_step_opd w_opd;
    t_step_res w_res;

    assign w_cr_in[0] = i_c_real_0;
    assign w_cr_in[1] = i_c_real_1;
    assign w_cr_in[2] = i_c_real_2;
    assign w_cr_in[3] = i_c_real_3;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_iter_end  = (r_iter == r_max_iter);
    assign w_last_lane = (r_lane == LW'(LANES - 1));
    assign w_adv       = ((r_state == S_SEL) && !w_iter_end && r_esc[r_lane])
                      || (r_state == S_UPD);
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_escape    = !w_res.inrange || (w_res.norm > r_esc_lim);

    assign w_opd.a  = r_za[r_lane];
    assign w_opd.b  = r_zb[r_lane];
    assign w_opd.cr = r_cr[r_lane];
    assign w_opd.ci = r_ci;

    mli_step_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_step (
        .i_clk  (i_clk),
        .i_state(r_state),
        .i_opd  (w_opd),
        .o_res  (w_res)
    );

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_in_valid ? S_SEL : S_IDLE;
            S_SEL: begin
                if (w_iter_end) begin
                    n_state = S_DONE;
                end else if (r_esc[r_lane]) begin
                    n_state = S_SEL;
                end else begin
                    n_state = S_AA;
                end
            end
            S_AA:    n_state = S_BB;
            S_BB:    n_state = S_AB;
            S_AB:    n_state = S_RI;
            S_RI:    n_state = S_RR;
            S_RR:    n_state = S_II;
            S_II:    n_state = S_UPD;
            S_UPD:   n_state = S_SEL;
            S_DONE:  n_state = w_load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_iter <= RST_MAX_ITER;
            r_norm_thr <= RST_NORM_THR;
            r_esc_lim  <= RST_ESC_LIM;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_ITER: r_max_iter <= i_cfg_wdata[ITER_W-1:0];
                    CFG_NORM_THR: r_norm_thr <= i_cfg_wdata[NORM_W-1:0];
                    CFG_ESC_LIM:  r_esc_lim  <= i_cfg_wdata[NORM_W-1:0];
                    default:      r_max_iter <= r_max_iter;
                endcase
            end
        end
    end

    // sequencer position: lane in the inner loop, iteration in the outer
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_lane <= '0;
            r_iter <= '0;
            r_ci   <= i_c_imag;
        end else if (w_adv) begin
            if (w_last_lane) begin
                r_lane <= '0;
                r_iter <= r_iter + 1'b1;
            end else begin
                r_lane <= r_lane + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= '0;
        end else if (w_in_acc) begin
            r_esc <= '0;
        end else if ((r_state == S_UPD) && w_escape) begin
            r_esc[r_lane] <= 1'b1;
        end
    end

    generate
        for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (w_in_acc) begin
                    r_za[gl]   <= '0;
                    r_zb[gl]   <= '0;
                    r_cr[gl]   <= w_cr_in[gl];
                    r_cnt[gl]  <= '0;
                    r_norm[gl] <= '0;
                end else if ((r_state == S_UPD) && (r_lane == LW'(gl))) begin
                    // count is tested before escape, so the escaping step can count
                    if (w_res.norm <= r_norm_thr) begin
                        r_cnt[gl] <= r_cnt[gl] + 1'b1;
                    end
                    if (w_escape) begin
                        r_norm[gl] <= NORM_SAT;
                    end else begin
                        r_norm[gl] <= w_res.norm;
                        r_za[gl]   <= w_res.re;
                        r_zb[gl]   <= w_res.im;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_load_out) begin
                    r_out_cnt[gl]  <= r_cnt[gl];
                    r_out_norm[gl] <= r_norm[gl];
                end
            end
        end

        for (genvar go = 0; go < MAX_LANES; go++) begin : g_out
            if (go < LANES) begin : g_used
                assign w_cnt_o[go]  = r_out_cnt[go];
                assign w_norm_o[go] = r_out_norm[go];
            end else begin : g_unused
                assign w_cnt_o[go]  = '0;
                assign w_norm_o[go] = '0;
            end
        end
    endgenerate

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count_0   = w_cnt_o[0];
    assign o_count_1   = w_cnt_o[1];
    assign o_count_2   = w_cnt_o[2];
    assign o_count_3   = w_cnt_o[3];
    assign o_norm_0    = w_norm_o[0];
    assign o_norm_1    = w_norm_o[1];
    assign o_norm_2    = w_norm_o[2];
    assign o_norm_3    = w_norm_o[3];

endmodule

>>> hdl/mli_checker.sv
// Port-level checks for the Mandelbrot lane iterator, bound to the top level.
module mli_checker import mli_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [CNT_W-1:0]  o_count_0,
    input logic [NORM_W-1:0] o_norm_0
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its lane 0 count and norm
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_count_0) && $stable(o_norm_0))
        else $error("result payload changed while stalled");

    // an accepted item occupies the iterator
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again straight after an item");

    // a new result only follows a busy period
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without work");

endmodule

bind mandelbrot_lane_iterator_top mli_checker u_mli_checker (.*);
